// ===== hdl/wsfe_pkg.sv =====
// Shared types, codes and constants of the WS2812 sign frame encoder.
package wsfe_pkg;

  localparam int unsigned MAX_PIXELS     = 1024;
  localparam int unsigned PIX_W          = $clog2(MAX_PIXELS);
  localparam int unsigned CNT_W          = PIX_W + 1;
  localparam int unsigned BITS_PER_PIXEL = 24;
  localparam int unsigned BIT_W          = 5;

  localparam logic [3:0] ONE_HIGH  = 4'd8;
  localparam logic [3:0] ONE_LOW   = 4'd4;
  localparam logic [3:0] ZERO_HIGH = 4'd4;
  localparam logic [3:0] ZERO_LOW  = 4'd8;

  localparam int unsigned PADDR_W = 5;

  // Register indexes, taken from paddr[4:2].
  localparam logic [2:0] REG_PIXEL_COUNT   = 3'd0;
  localparam logic [2:0] REG_SIGN_SIZE     = 3'd1;
  localparam logic [2:0] REG_LOCATOR_INDEX = 3'd2;
  localparam logic [2:0] REG_LOCATOR_COLOR = 3'd3;
  localparam logic [2:0] REG_WHITE_LEVEL   = 3'd4;
  localparam logic [2:0] REG_REFRESH_MS    = 3'd5;

  localparam logic [10:0] RST_PIXEL_COUNT   = 11'd10;
  localparam logic [7:0]  RST_SIGN_SIZE     = 8'd10;
  localparam logic [7:0]  RST_LOCATOR_INDEX = 8'd0;
  localparam logic [23:0] RST_LOCATOR_COLOR = 24'hFF0000;
  localparam logic [7:0]  RST_WHITE_LEVEL   = 8'd255;
  localparam logic [15:0] RST_REFRESH_MS    = 16'd250;

  typedef enum logic [2:0] {
    OP_MS_TICK     = 3'd0,
    OP_SET_NORMAL  = 3'd1,
    OP_SET_WHITE   = 3'd2,
    OP_BLACKOUT    = 3'd3,
    OP_WRITE_RGB   = 3'd4,
    OP_NEXT_SYMBOL = 3'd5
  } op_e;

  typedef struct packed {
    logic [10:0] pixel_count;
    logic [7:0]  sign_size;
    logic [7:0]  locator_index;
    logic [23:0] locator_color;
    logic [7:0]  white_level;
    logic [15:0] refresh_ms;
  } cfg_t;

  typedef struct packed {
    logic [3:0] high_ticks;
    logic [3:0] low_ticks;
    logic       last_symbol;
  } sym_t;

endpackage

// ===== hdl/ws2812_sign_frame_encoder_unit.sv =====
// Top level of the WS2812 sign frame encoder: input register, core and result register.
// A request transfers into the input register, the core processes it from there and the
// symbol it yields is loaded into the result register, which offers it on the symbol stream.
// Throughput: one input transfer per cycle, held off while a stalled symbol waits to transfer.
// Reset (rst_ni, asynchronous, active low) empties both registers, clears the frame
// state and restores the configuration registers to their defaults.
module ws2812_sign_frame_encoder_unit import wsfe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Request stream.
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [23:0]        s_axis_tdata,  // red [7:0], green [15:8], blue [23:16]
  input  logic [2:0]         s_axis_tuser,  // operation [2:0]
  // Symbol stream.
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata,  // high_ticks [3:0], low_ticks [7:4]
  output logic               m_axis_tlast,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t        cfg;
  logic        in_valid_q, in_valid_d;
  op_e         in_op_q;
  logic [23:0] in_rgb_q;
  logic        out_valid_q, out_valid_d;
  sym_t        out_sym_q;
  logic        fire;
  logic        in_accept;
  logic        sym_valid;
  sym_t        sym;

  wsfe_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The held request is processed once the result register is empty or
  // is being emptied by a transfer in the same cycle.
  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (in_accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Request payload needs no reset; it is qualified by in_valid_q.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_op_q  <= op_e'(s_axis_tuser);
      in_rgb_q <= s_axis_tdata;
    end
  end

  wsfe_symbol_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .op_i        (in_op_q),
    .red_i       (in_rgb_q[7:0]),
    .green_i     (in_rgb_q[15:8]),
    .blue_i      (in_rgb_q[23:16]),
    .cfg_i       (cfg),
    .sym_valid_o (sym_valid),
    .sym_o       (sym)
  );

  // Only a next-symbol request inside a frame loads the result register;
  // every other processed request just lets a pending result drain.
  always_comb begin
    if (fire) begin
      out_valid_d = sym_valid;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && sym_valid) begin
      out_sym_q <= sym;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_sym_q.low_ticks, out_sym_q.high_ticks};
  assign m_axis_tlast  = out_sym_q.last_symbol;

endmodule

// ===== hdl/wsfe_cfg_regs.sv =====
// APB register file holding the encoder configuration.
module wsfe_cfg_regs import wsfe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic [2:0] idx;
  logic       wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[PADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_PIXEL_COUNT:   cfg_d.pixel_count   = pwdata[10:0];
        REG_SIGN_SIZE:     cfg_d.sign_size     = pwdata[7:0];
        REG_LOCATOR_INDEX: cfg_d.locator_index = pwdata[7:0];
        REG_LOCATOR_COLOR: cfg_d.locator_color = pwdata[23:0];
        REG_WHITE_LEVEL:   cfg_d.white_level   = pwdata[7:0];
        REG_REFRESH_MS:    cfg_d.refresh_ms    = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PIXEL_COUNT:   prdata = {21'd0, cfg_q.pixel_count};
      REG_SIGN_SIZE:     prdata = {24'd0, cfg_q.sign_size};
      REG_LOCATOR_INDEX: prdata = {24'd0, cfg_q.locator_index};
      REG_LOCATOR_COLOR: prdata = {8'd0, cfg_q.locator_color};
      REG_WHITE_LEVEL:   prdata = {24'd0, cfg_q.white_level};
      REG_REFRESH_MS:    prdata = {16'd0, cfg_q.refresh_ms};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_count   <= RST_PIXEL_COUNT;
      cfg_q.sign_size     <= RST_SIGN_SIZE;
      cfg_q.locator_index <= RST_LOCATOR_INDEX;
      cfg_q.locator_color <= RST_LOCATOR_COLOR;
      cfg_q.white_level   <= RST_WHITE_LEVEL;
      cfg_q.refresh_ms    <= RST_REFRESH_MS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/wsfe_symbol_core.sv =====
// Frame state and per-request symbol generation of the encoder.
module wsfe_symbol_core import wsfe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  op_e         op_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  cfg_t        cfg_i,
  output logic        sym_valid_o,
  output sym_t        sym_o
);

  logic                      white_q, white_d;
  logic [15:0]               ms_q, ms_d;
  logic                      frame_q, frame_d;
  logic                      pattern_q, pattern_d;
  logic [23:0]               color_q, color_d;
  logic [PIX_W-1:0]          pix_q, pix_d;
  logic [BIT_W-1:0]          bit_q, bit_d;
  logic [7:0]                pos_q, pos_d;

  logic                      start;
  logic                      start_pattern;
  logic [23:0]               start_color;
  logic [CNT_W-1:0]          eff_count;
  logic [7:0]                size;
  logic [23:0]               pix_color;
  logic [23:0]               white_color;
  logic                      bit_val;
  logic                      bit_end;
  logic                      last;
  logic [8:0]                pos_inc;
  logic [15:0]               ms_inc;

  always_comb begin
    if (cfg_i.pixel_count == '0) begin
      eff_count = CNT_W'(1);
    end else if (32'(cfg_i.pixel_count) > MAX_PIXELS) begin
      eff_count = CNT_W'(MAX_PIXELS);
    end else begin
      eff_count = CNT_W'(cfg_i.pixel_count);
    end
  end

  assign size        = (cfg_i.sign_size == '0) ? 8'd1 : cfg_i.sign_size;
  assign white_color = {cfg_i.white_level, cfg_i.white_level, cfg_i.white_level};
  assign pix_color   = pattern_q ? ((pos_q == cfg_i.locator_index) ?
                                    cfg_i.locator_color : 24'd0) : color_q;
  assign bit_val     = pix_color[BIT_W'(BITS_PER_PIXEL - 1) - bit_q];
  assign bit_end     = (bit_q == BIT_W'(BITS_PER_PIXEL - 1));
  assign last        = bit_end && ((CNT_W'(pix_q) + CNT_W'(1)) >= eff_count);
  assign pos_inc     = {1'b0, pos_q} + 9'd1;
  assign ms_inc      = (ms_q != '1) ? ms_q + 16'd1 : ms_q;

  always_comb begin
    white_d       = white_q;
    ms_d          = ms_q;
    frame_d       = frame_q;
    pattern_d     = pattern_q;
    color_d       = color_q;
    pix_d         = pix_q;
    bit_d         = bit_q;
    pos_d         = pos_q;
    start         = 1'b0;
    start_pattern = 1'b0;
    start_color   = '0;
    sym_valid_o   = 1'b0;
    sym_o.high_ticks  = bit_val ? ONE_HIGH : ZERO_HIGH;
    sym_o.low_ticks   = bit_val ? ONE_LOW : ZERO_LOW;
    sym_o.last_symbol = last;

    if (fire_i) begin
      unique case (op_i)
        OP_MS_TICK: begin
          if (white_q) begin
            ms_d = ms_inc;
            if (ms_inc >= cfg_i.refresh_ms) begin
              ms_d        = '0;
              start       = 1'b1;
              start_color = white_color;
            end
          end
        end
        OP_SET_NORMAL: begin
          white_d       = 1'b0;
          start         = 1'b1;
          start_pattern = 1'b1;
        end
        OP_SET_WHITE: begin
          white_d     = 1'b1;
          ms_d        = '0;
          start       = 1'b1;
          start_color = white_color;
        end
        OP_BLACKOUT: begin
          white_d = 1'b0;
          start   = 1'b1;
        end
        OP_WRITE_RGB: begin
          start       = 1'b1;
          start_color = {green_i, red_i, blue_i};
        end
        OP_NEXT_SYMBOL: begin
          if (frame_q) begin
            sym_valid_o = 1'b1;
            if (last) begin
              frame_d = 1'b0;
              pix_d   = '0;
              bit_d   = '0;
              pos_d   = '0;
            end else if (bit_end) begin
              bit_d = '0;
              pix_d = pix_q + PIX_W'(1);
              pos_d = (pos_inc >= {1'b0, size}) ? 8'd0 : pos_inc[7:0];
            end else begin
              bit_d = bit_q + BIT_W'(1);
            end
          end
        end
        default: ;
      endcase
    end

    if (start) begin
      frame_d   = 1'b1;
      pattern_d = start_pattern;
      color_d   = start_color;
      pix_d     = '0;
      bit_d     = '0;
      pos_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      white_q   <= 1'b0;
      ms_q      <= '0;
      frame_q   <= 1'b0;
      pattern_q <= 1'b0;
      color_q   <= '0;
      pix_q     <= '0;
      bit_q     <= '0;
      pos_q     <= '0;
    end else begin
      white_q   <= white_d;
      ms_q      <= ms_d;
      frame_q   <= frame_d;
      pattern_q <= pattern_d;
      color_q   <= color_d;
      pix_q     <= pix_d;
      bit_q     <= bit_d;
      pos_q     <= pos_d;
    end
  end

endmodule

// ===== hdl/wsfe_checker.sv =====
// Port-level checks of the encoder streams, bound to the top level.
module wsfe_checker import wsfe_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [2:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast
);

  // A stalled symbol stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled symbol changed or dropped");

  // Every symbol is a well-formed one or zero bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tdata[3:0] == ONE_HIGH && m_axis_tdata[7:4] == ONE_LOW) ||
      (m_axis_tdata[3:0] == ZERO_HIGH && m_axis_tdata[7:4] == ZERO_LOW))
    else $error("malformed symbol durations");

  // A symbol that appears on an idle output comes from a next-symbol request
  // that was taken into the input register and then processed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |->
      $past(s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_NEXT_SYMBOL, 2))
    else $error("symbol without a next-symbol request");

endmodule

bind ws2812_sign_frame_encoder_unit wsfe_checker u_wsfe_checker (.*);
